// File: hdl/swfd_pkg.sv
`timescale 1ns / 1ps
package swfd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 4;

  // Request codes.
  localparam logic [1:0] REQ_VOLT  = 2'd0;
  localparam logic [1:0] REQ_TEMP  = 2'd1;
  localparam logic [1:0] REQ_ACCEL = 2'd2;
  localparam logic [1:0] REQ_EVAL  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_TOL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_RANGE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_RANGE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIM   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LEVEL  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_BAT  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_BAT   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_DROP   = 4'd7;

  // Register reset values.
  localparam logic [15:0] RST_NOISE_TOL  = 16'd100;
  localparam logic [15:0] RST_VOLT_RANGE = 16'd500;
  localparam logic [15:0] RST_TEMP_RANGE = 16'd1000;
  localparam logic [15:0] RST_STEP_LIM   = 16'd2000;
  localparam logic [15:0] RST_SAT_LEVEL  = 16'd6000;
  localparam logic [15:0] RST_SPIKE_BAT  = 16'd3200;
  localparam logic [15:0] RST_MISS_BAT   = 16'd3300;
  localparam logic [15:0] RST_ACT_DROP   = 16'd5000;

  // Extreme temperature band in centidegrees.
  localparam logic signed [15:0] TEMP_HIGH = 16'sd5000;
  localparam logic signed [15:0] TEMP_LOW  = -16'sd1000;

  // Trend and missing-data cause codes.
  localparam logic [1:0] TREND_NONE = 2'd0;
  localparam logic [1:0] TREND_TEMP = 2'd1;
  localparam logic [1:0] TREND_ACT  = 2'd2;
  localparam logic [1:0] MISS_SAT   = 2'd0;
  localparam logic [1:0] MISS_BAT   = 2'd1;
  localparam logic [1:0] MISS_TEMP  = 2'd2;
  localparam logic [1:0] MISS_HWSW  = 2'd3;

  localparam int DEF_ACCEL_DEPTH    = 4096;
  localparam int DEF_ACTIVATION_LAG = 2000;

  // Statistics of one scalar channel.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SAMPLE_W-1:0] last_v;
    logic                       seen;
  } chan_stat_t;

endpackage

// File: hdl/swfd_chan_track.sv
`timescale 1ns / 1ps
module swfd_chan_track (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  upd,
  input  logic                                  clr,
  input  logic signed [swfd_pkg::SAMPLE_W-1:0]  sample,
  output swfd_pkg::chan_stat_t                  stat
);
  import swfd_pkg::*;

  chan_stat_t stat_r;

  // Minimum, maximum and last value; the first sample sets both bounds.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      stat_r <= '0;
    end else if (upd) begin
      if (!stat_r.seen || sample < stat_r.min_v) stat_r.min_v <= sample;
      if (!stat_r.seen || sample > stat_r.max_v) stat_r.max_v <= sample;
      stat_r.last_v <= sample;
      stat_r.seen   <= 1'b1;
    end
  end

  assign stat = stat_r;

endmodule

// File: hdl/swfd_accel_mem.sv
`timescale 1ns / 1ps
module swfd_accel_mem #(
  parameter int DEPTH = swfd_pkg::DEF_ACCEL_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic [swfd_pkg::SAMPLE_W-1:0]        wdata,
  input  logic [AW-1:0]                        raddr,
  output logic [swfd_pkg::SAMPLE_W-1:0]        rdata
);
  import swfd_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sensor_window_fault_diagnosis.sv
`timescale 1ns / 1ps
// Voltage, temperature and acceleration samples are taken one word per cycle;
// a sample word never produces a result. An evaluate word judges the window and
// returns one result word, then clears the window. Evaluation walks the stored
// acceleration samples through the single read port of the sample memory, one
// entry per cycle. After an evaluate word the block steps through its prepare,
// walk, drain and done states before the next input word is accepted, and it
// waits in done while an earlier result word is still waiting to be taken;
// no input word is taken during that time. A waiting result does not stop new
// sample words. Samples beyond ACCEL_DEPTH are dropped and mark the window
// invalid. Configuration writes are accepted in every cycle.
module sensor_window_fault_diagnosis #(
  parameter int ACCEL_DEPTH    = swfd_pkg::DEF_ACCEL_DEPTH,
  parameter int ACTIVATION_LAG = swfd_pkg::DEF_ACTIVATION_LAG
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_req_type,
  input  logic signed [swfd_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic                                  in_previous_constant,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_drift_flag,
  output logic [1:0]                            out_trend_cause,
  output logic                                  out_minor_flag,
  output logic                                  out_square_flag,
  output logic                                  out_bias_flag,
  output logic                                  out_rotation_flag,
  output logic                                  out_spike_cause,
  output logic [1:0]                            out_missing_cause,
  output logic                                  out_window_valid,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                           cfg_data
);
  import swfd_pkg::*;

  localparam int CW = $clog2(ACCEL_DEPTH + 1);
  localparam int AW = $clog2(ACCEL_DEPTH);
  localparam int SW = SAMPLE_W + CW;
  localparam int PW = SAMPLE_W + CW + 1;
  localparam int EW = SAMPLE_W + CW + 5;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] st_r, st_nxt;

  // Configuration registers.
  logic [15:0]        noise_tol_r, volt_range_r, temp_range_r, step_lim_r;
  logic signed [15:0] sat_level_r;
  logic [15:0]        spike_bat_r, miss_bat_r, act_drop_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_tol_r  <= RST_NOISE_TOL;
      volt_range_r <= RST_VOLT_RANGE;
      temp_range_r <= RST_TEMP_RANGE;
      step_lim_r   <= RST_STEP_LIM;
      sat_level_r  <= RST_SAT_LEVEL;
      spike_bat_r  <= RST_SPIKE_BAT;
      miss_bat_r   <= RST_MISS_BAT;
      act_drop_r   <= RST_ACT_DROP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NOISE_TOL:  noise_tol_r  <= cfg_data;
        REG_VOLT_RANGE: volt_range_r <= cfg_data;
        REG_TEMP_RANGE: temp_range_r <= cfg_data;
        REG_STEP_LIM:   step_lim_r   <= cfg_data;
        REG_SAT_LEVEL:  sat_level_r  <= cfg_data;
        REG_SPIKE_BAT:  spike_bat_r  <= cfg_data;
        REG_MISS_BAT:   miss_bat_r   <= cfg_data;
        REG_ACT_DROP:   act_drop_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word decode.
  logic in_acc, acc_volt, acc_temp, acc_accel, acc_eval;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign acc_volt  = in_acc && (in_req_type == REQ_VOLT);
  assign acc_temp  = in_acc && (in_req_type == REQ_TEMP);
  assign acc_accel = in_acc && (in_req_type == REQ_ACCEL);
  assign acc_eval  = in_acc && (in_req_type == REQ_EVAL);

  logic       win_clr;
  chan_stat_t volt_st, temp_st;

  assign win_clr = (st_r == ST_DONE) && (!out_valid || out_ready);

  swfd_chan_track u_volt (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (acc_volt),
    .clr    (win_clr),
    .sample (in_sample_value),
    .stat   (volt_st)
  );

  swfd_chan_track u_temp (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (acc_temp),
    .clr    (win_clr),
    .sample (in_sample_value),
    .stat   (temp_st)
  );

  // Acceleration loading: running sum, largest step, first and lagged sample.
  logic [CW-1:0]              count_r;
  logic signed [SW-1:0]       sum_r;
  logic [16:0]                lstep_r;
  logic                       ovf_r;
  logic signed [15:0]         prev_r, first_r, lag_r;
  logic                       room;
  logic                       mem_we;
  logic signed [16:0]         step_diff;
  logic [16:0]                step_abs;

  assign room      = (count_r < CW'(ACCEL_DEPTH));
  assign mem_we    = acc_accel && room;
  assign step_diff = {in_sample_value[15], in_sample_value} - {prev_r[15], prev_r};
  assign step_abs  = step_diff[16] ? 17'(-step_diff) : 17'(step_diff);

  always_ff @(posedge clk) begin
    if (!rst_n || win_clr) begin
      count_r <= '0;
      sum_r   <= '0;
      lstep_r <= '0;
      ovf_r   <= 1'b0;
    end else if (acc_accel) begin
      if (room) begin
        if (count_r != '0 && step_abs > lstep_r) lstep_r <= step_abs;
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SW'(in_sample_value);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prev_r <= in_sample_value;
      if (count_r == '0) first_r <= in_sample_value;
      if (32'(count_r) == ACTIVATION_LAG) lag_r <= in_sample_value;
    end
  end

  // Sample memory. Loading and the evaluation walk never overlap in time.
  logic [CW-1:0]       rd_cnt_r;
  logic [15:0]         rd_data;
  logic                rd_issue;

  assign rd_issue = (st_r == ST_WALK) && (rd_cnt_r < count_r);

  swfd_accel_mem #(
    .DEPTH (ACCEL_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_sample_value),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (rd_data)
  );

  // Scaled limits, computed once per evaluation.
  logic [SW-1:0]        tol_n_r;
  logic [SW+2:0]        tol5_n_r;
  logic signed [PW-1:0] sat_n_r;
  logic                 prev_const_r;
  logic [18:0]          tol5;

  assign tol5 = {noise_tol_r, 2'b00} + 19'(noise_tol_r);

  always_ff @(posedge clk) begin
    if (acc_eval) prev_const_r <= in_previous_constant;
    if (st_r == ST_PREP) begin
      tol_n_r  <= noise_tol_r * count_r;
      tol5_n_r <= tol5 * count_r;
      sat_n_r  <= sat_level_r * $signed({1'b0, count_r});
    end
  end

  // Walk pipeline: read, multiply by count, compare against the scaled limits.
  logic                 v1_r, v2_r, first1_r, first2_r;
  logic signed [PW-1:0] prod_r;
  logic signed [EW-1:0] dev;
  logic [EW-1:0]        dev_abs;
  logic                 flat_r, bias_r;

  assign dev     = EW'(prod_r) - EW'(sum_r);
  assign dev_abs = dev[EW-1] ? EW'(-dev) : EW'(dev);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= rd_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (rd_cnt_r == '0);
    first2_r <= first1_r;
    prod_r   <= $signed(rd_data) * $signed({1'b0, count_r});
    if (st_r == ST_PREP) begin
      rd_cnt_r <= '0;
      flat_r   <= !(lstep_r > 17'(noise_tol_r));
      bias_r   <= 1'b0;
    end else begin
      if (rd_issue) rd_cnt_r <= rd_cnt_r + 1'b1;
      if (v2_r) begin
        if (!first2_r && dev_abs > EW'(tol_n_r)) flat_r <= 1'b0;
        if (dev_abs > EW'(tol5_n_r)) bias_r <= 1'b1;
      end
    end
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (acc_eval) st_nxt = ST_PREP;
      ST_PREP:  st_nxt = ST_WALK;
      ST_WALK:  if (!rd_issue) st_nxt = ST_DRAIN;
      ST_DRAIN: if (!v1_r && !v2_r) st_nxt = ST_DONE;
      ST_DONE:  if (win_clr) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // Final verdicts.
  logic signed [17:0] volt_spread, temp_spread, act_diff;
  logic               drift, minor, square, rot, spike, valid;
  logic [1:0]         trend, miss;

  assign volt_spread = 18'(volt_st.max_v) - 18'(volt_st.min_v);
  assign temp_spread = 18'(temp_st.max_v) - 18'(temp_st.min_v);
  assign act_diff    = 18'(first_r) - 18'(lag_r);

  always_comb begin
    drift  = volt_spread > $signed({2'b00, volt_range_r});
    minor  = lstep_r < 17'(noise_tol_r);
    rot    = lstep_r > 17'(step_lim_r);
    square = (count_r != '0) && flat_r && (EW'(sum_r) >= EW'(sat_n_r));
    spike  = !(17'(volt_st.last_v) < $signed({1'b0, spike_bat_r}));
    valid  = volt_st.seen && temp_st.seen && (count_r != '0) && !ovf_r;
    priority if (temp_spread > $signed({2'b00, temp_range_r})) begin
      trend = TREND_TEMP;
    end else if ((32'(count_r) > ACTIVATION_LAG) &&
                 (act_diff >= $signed({2'b00, act_drop_r}))) begin
      trend = TREND_ACT;
    end else begin
      trend = TREND_NONE;
    end
    priority if (!prev_const_r) begin
      miss = MISS_SAT;
    end else if (17'(volt_st.last_v) < $signed({1'b0, miss_bat_r})) begin
      miss = MISS_BAT;
    end else if (temp_st.last_v > TEMP_HIGH || temp_st.last_v < TEMP_LOW) begin
      miss = MISS_TEMP;
    end else begin
      miss = MISS_HWSW;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (win_clr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_clr) begin
      out_drift_flag    <= drift;
      out_trend_cause   <= trend;
      out_minor_flag    <= minor;
      out_square_flag   <= square;
      out_bias_flag     <= (count_r != '0) && bias_r;
      out_rotation_flag <= rot;
      out_spike_cause   <= spike;
      out_missing_cause <= miss;
      out_window_valid  <= valid;
    end
  end

endmodule

// File: hdl/swfd_checker.sv
`timescale 1ns / 1ps
module swfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready
);
  import swfd_pkg::*;

  // A result word stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // An evaluate word starts a walk, so the input side closes next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_EVAL |=> !in_ready)
    else $error("input accepted right after an evaluate word");

  // A sample word never brings out a result of its own.
  a_sample_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && in_req_type != REQ_EVAL |=> !out_valid)
    else $error("result appeared after a sample word");

endmodule

bind sensor_window_fault_diagnosis swfd_checker u_swfd_checker (.*);

// File: tb/sv/tb_sensor_window_fault_diagnosis.sv
`timescale 1ns / 1ps
module tb_sensor_window_fault_diagnosis;
  import swfd_pkg::*;

  localparam int DEPTH = DEF_ACCEL_DEPTH;
  localparam int LAG   = DEF_ACTIVATION_LAG;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]         req;
    logic signed [15:0] sample;
    logic               prev_const;
  } sensor_word_t;

  typedef struct packed {
    logic       drift;
    logic [1:0] trend;
    logic       minor;
    logic       square;
    logic       bias;
    logic       rotation;
    logic       spike;
    logic [1:0] missing;
    logic       valid;
  } diag_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = REQ_VOLT;
  logic signed [15:0] in_sample_value = '0;
  logic in_previous_constant = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_drift_flag, out_minor_flag, out_square_flag, out_bias_flag;
  logic out_rotation_flag, out_spike_cause, out_window_valid;
  logic [1:0] out_trend_cause, out_missing_cause;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NOISE_TOL;
  logic [15:0] cfg_data = '0;

  sensor_window_fault_diagnosis i_dut (.*);

  always #5 clk = ~clk;

  // Predictor copy of the configuration and the window.
  logic [15:0] tol_q, vrange_q, trange_q, steplim_q, spikebat_q, missbat_q, actdrop_q;
  logic signed [15:0] satlvl_q;
  int vmin, vmax, vlast, tmin, tmax, tlast;
  bit vseen, tseen, acc_ovf;
  int acc_mem [DEPTH];
  int acc_cnt;
  longint acc_sum;
  int big_step;

  sensor_word_t pending_words[$];
  diag_word_t   expected_diags[$];
  int  fail_count = 0;
  int  diag_count = 0;
  bit  quiet = 1'b0;
  bit  hold_sender = 1'b0;
  longint cycles = 0;

  task automatic clear_window();
    vmin = 0; vmax = 0; vlast = 0; tmin = 0; tmax = 0; tlast = 0;
    vseen = 0; tseen = 0; acc_ovf = 0; acc_cnt = 0; acc_sum = 0; big_step = 0;
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      REG_NOISE_TOL:  tol_q = val;
      REG_VOLT_RANGE: vrange_q = val;
      REG_TEMP_RANGE: trange_q = val;
      REG_STEP_LIM:   steplim_q = val;
      REG_SAT_LEVEL:  satlvl_q = val;
      REG_SPIKE_BAT:  spikebat_q = val;
      REG_MISS_BAT:   missbat_q = val;
      REG_ACT_DROP:   actdrop_q = val;
      default: ;
    endcase
  endtask

  // Update the window with one accepted word; an evaluate word yields a diagnosis.
  task automatic diagnose_word(sensor_word_t w);
    int s;
    int d;
    longint n, tol, dev;
    bit flat;
    diag_word_t r;
    s = w.sample;
    case (w.req)
      REQ_VOLT: begin
        if (!vseen || s < vmin) vmin = s;
        if (!vseen || s > vmax) vmax = s;
        vlast = s; vseen = 1;
      end
      REQ_TEMP: begin
        if (!tseen || s < tmin) tmin = s;
        if (!tseen || s > tmax) tmax = s;
        tlast = s; tseen = 1;
      end
      REQ_ACCEL: begin
        if (acc_cnt < DEPTH) begin
          if (acc_cnt > 0) begin
            d = s - acc_mem[acc_cnt-1];
            if (d < 0) d = -d;
            if (d > big_step) big_step = d;
          end
          acc_mem[acc_cnt] = s;
          acc_cnt++;
          acc_sum += s;
        end else begin
          acc_ovf = 1;
        end
      end
      default: begin
        n = acc_cnt;
        tol = tol_q;
        flat = 1;
        r = '0;
        r.drift = (longint'(vmax) - vmin > longint'(vrange_q));
        if (longint'(tmax) - tmin > longint'(trange_q)) r.trend = TREND_TEMP;
        else if (acc_cnt > LAG && longint'(acc_mem[0]) - acc_mem[LAG] >= longint'(actdrop_q))
          r.trend = TREND_ACT;
        else r.trend = TREND_NONE;
        r.minor = (big_step < tol);
        r.rotation = (big_step > longint'(steplim_q));
        if (acc_cnt > 0) begin
          if (big_step > tol) flat = 0;
          for (int i = 0; i < acc_cnt; i++) begin
            dev = longint'(acc_mem[i]) * n - acc_sum;
            if (dev < 0) dev = -dev;
            if (i > 0 && dev > tol * n) flat = 0;
            if (dev > 5 * tol * n) r.bias = 1;
          end
          if (flat && acc_sum >= longint'(satlvl_q) * n) r.square = 1;
        end
        r.spike = !(vlast < longint'(spikebat_q));
        if (!w.prev_const) r.missing = MISS_SAT;
        else if (vlast < longint'(missbat_q)) r.missing = MISS_BAT;
        else if (tlast > TEMP_HIGH || tlast < TEMP_LOW) r.missing = MISS_TEMP;
        else r.missing = MISS_HWSW;
        r.valid = vseen && tseen && acc_cnt > 0 && !acc_ovf;
        expected_diags.push_back(r);
        clear_window();
      end
    endcase
  endtask

  // Driver: present the next pending word, with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        diagnose_word('{in_req_type, in_sample_value, in_previous_constant});
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
          send_gap <= $urandom_range(1, 17);
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          {in_req_type, in_sample_value, in_previous_constant} <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receive with random stalls and compare each result word.
  int recv_gap = 0;
  diag_word_t got, want;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_drift_flag, out_trend_cause, out_minor_flag, out_square_flag,
                out_bias_flag, out_rotation_flag, out_spike_cause, out_missing_cause,
                out_window_valid};
        diag_count <= diag_count + 1;
        if (expected_diags.size() == 0) begin
          $error("unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_diags.pop_front();
          if (got.drift !== want.drift) $error("drift_flag exp %0d got %0d", want.drift, got.drift);
          if (got.trend !== want.trend) $error("trend_cause exp %0d got %0d", want.trend, got.trend);
          if (got.minor !== want.minor) $error("minor_flag exp %0d got %0d", want.minor, got.minor);
          if (got.square !== want.square)
            $error("square_flag exp %0d got %0d", want.square, got.square);
          if (got.bias !== want.bias) $error("bias_flag exp %0d got %0d", want.bias, got.bias);
          if (got.rotation !== want.rotation)
            $error("rotation_flag exp %0d got %0d", want.rotation, got.rotation);
          if (got.spike !== want.spike)
            $error("spike_cause exp %0d got %0d", want.spike, got.spike);
          if (got.missing !== want.missing)
            $error("missing_cause exp %0d got %0d", want.missing, got.missing);
          if (got.valid !== want.valid)
            $error("window_valid exp %0d got %0d", want.valid, got.valid);
          if (got !== want) fail_count <= fail_count + 1;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_word(logic [1:0] req, logic [15:0] val, logic pc);
    pending_words.push_back('{req, val, pc});
  endtask

  // Random window: mostly well-formed, with small acceleration sets.
  task automatic add_window(int accel_n, bit tame);
    int base;
    base = $urandom_range(0, 65535);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1))
        add_word(REQ_VOLT, tame ? 16'($urandom_range(2800, 3800)) : 16'($urandom),
                 1'($urandom));
      else
        add_word(REQ_TEMP, tame ? 16'($urandom_range(0, 6000) - 1500) : 16'($urandom),
                 1'($urandom));
    end
    for (int i = 0; i < accel_n; i++)
      add_word(REQ_ACCEL, tame ? 16'(base + $urandom_range(0, 300)) : 16'($urandom),
               1'($urandom));
    if ($urandom_range(0, 3) != 0)
      add_word(REQ_VOLT, 16'($urandom_range(2800, 3800)), 1'($urandom));
    if ($urandom_range(0, 3) != 0)
      add_word(REQ_TEMP, 16'($urandom_range(0, 7000) - 1500), 1'($urandom));
    add_word(REQ_EVAL, 16'($urandom), 1'($urandom));
  endtask

  // Configuration write while idle; model updated on acceptance.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pending_words.size() > 0 || in_valid || expected_diags.size() > 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_all(bit [1:0] mode);
    for (int r = 0; r < 8; r++) begin
      logic [15:0] v;
      case (mode)
        2'd0: v = 16'h0000;
        2'd1: v = 16'hFFFF;
        2'd2: v = (r == 4) ? 16'h8000 : 16'h7FFF;
        default: v = $urandom_range(0, 3000);
      endcase
      write_reg(r[CFG_IDX_W-1:0], v);
    end
  endtask

  initial begin
    tol_q = RST_NOISE_TOL; vrange_q = RST_VOLT_RANGE; trange_q = RST_TEMP_RANGE;
    steplim_q = RST_STEP_LIM; satlvl_q = RST_SAT_LEVEL; spikebat_q = RST_SPIKE_BAT;
    missbat_q = RST_MISS_BAT; actdrop_q = RST_ACT_DROP;
    clear_window();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, empty windows, flat saturated window.
    add_word(REQ_EVAL, 16'h0000, 1'b1);
    add_word(REQ_VOLT, 16'h8000, 1'b0);
    add_word(REQ_VOLT, 16'h7FFF, 1'b1);
    add_word(REQ_TEMP, 16'h7FFF, 1'b0);
    add_word(REQ_TEMP, 16'h8000, 1'b1);
    add_word(REQ_ACCEL, 16'h8000, 1'b0);
    add_word(REQ_ACCEL, 16'h7FFF, 1'b1);
    add_word(REQ_EVAL, 16'hFFFF, 1'b1);
    add_word(REQ_VOLT, 16'd3250, 1'b0);
    add_word(REQ_TEMP, 16'd6000, 1'b0);
    repeat (4) add_word(REQ_ACCEL, 16'd7000, 1'b0);
    add_word(REQ_EVAL, 16'd0, 1'b1);
    add_word(REQ_VOLT, 16'd4000, 1'b0);
    add_word(REQ_TEMP, -16'sd2000, 1'b0);
    add_word(REQ_ACCEL, 16'd10, 1'b0);
    add_word(REQ_ACCEL, 16'd900, 1'b0);
    add_word(REQ_EVAL, 16'd0, 1'b1);
    add_word(REQ_ACCEL, 16'd5, 1'b0);
    add_word(REQ_EVAL, 16'd0, 1'b0);
    drain_and_settle();

    // Random phases over several register settings, extremes first.
    for (int ph = 0; ph < 5; ph++) begin
      write_all(ph < 3 ? ph[1:0] : 2'd3);
      repeat (9) add_window($urandom_range(0, 6), $urandom_range(0, 3) != 0);
      if (ph == 2) begin
        // Sender holds off until every expected result has come.
        while (pending_words.size() > 10) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_diags.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain_and_settle();
    end
    write_reg(REG_NOISE_TOL, RST_NOISE_TOL);

    // Last part without idling.
    quiet = 1'b1;
    repeat (10) add_window($urandom_range(1, 5), 1'b1);
    drain_and_settle();

    $display("Covered %0d diagnosis results over extreme and random register settings,",
             diag_count);
    $display("including empty windows, extreme samples and a flat saturated window.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
